[rtl/bso_pkg.sv]
`default_nettype none

package bso_pkg;

    // Three spatial axes, one lane each
    localparam int NUM_AXES = 3;

    // Stage advance enables for the pipelined squarer
    typedef struct packed {
        logic adv_s2;   // partial products
        logic adv_s3;   // square assembly
    } bso_sq_ctrl_t;

    // Stage advance enables for the merge stages
    typedef struct packed {
        logic adv_s4;   // sum of axis squares
        logic adv_s5;   // compare against radius squared
    } bso_merge_ctrl_t;

endpackage

`default_nettype wire

[rtl/box_sphere_overlap_test_top.sv]
`default_nettype none

// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// input    | s_valid / s_ready  | s_box_min_*, s_box_max_*, s_centre_*, s_radius
// result   | m_valid / m_ready  | m_hit, m_near_x, m_near_y, m_near_z
//
// One item per cycle sustained while m_ready is high; each result passes through the stages below in order.
// Stages: clamp lanes, partial products, square assembly, sum, compare.
// Each stage advances when it is empty or the next stage advances, so a
// stall on m_ready fills bubbles before s_ready drops.
// Reset clears only the stage valid bits.
module box_sphere_overlap_test_top #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_min_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_min_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_min_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_max_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_max_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_max_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_centre_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_centre_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_centre_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_radius,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic signed [COORD_WIDTH-1:0]      m_near_x,
    output logic signed [COORD_WIDTH-1:0]      m_near_y,
    output logic signed [COORD_WIDTH-1:0]      m_near_z
);

    localparam int NA = bso_pkg::NUM_AXES;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    bso_pkg::bso_sq_ctrl_t    sq_ctrl;
    bso_pkg::bso_merge_ctrl_t mg_ctrl;

    logic signed [NA-1:0][COORD_WIDTH-1:0] box_lo, box_hi, ctr;
    logic        [NA-1:0][COORD_WIDTH-1:0] gap;
    logic signed [NA-1:0][COORD_WIDTH-1:0] near_s1;
    logic signed [NA-1:0][COORD_WIDTH-1:0] near_s2_reg, near_s3_reg;
    logic signed [NA-1:0][COORD_WIDTH-1:0] near_s4_reg, near_s5_reg;
    logic        [NA-1:0][2*COORD_WIDTH-1:0] sq_dist;

    logic [COORD_WIDTH-1:0]   rmag_reg, rmag_next;
    logic [2*COORD_WIDTH-1:0] r_sq;
    logic                     hit;

    // Backpressure chain: a stage moves when empty or when the next one moves
    assign adv5 = !v5_reg || m_ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_ready = adv1;

    assign sq_ctrl.adv_s2 = adv2;
    assign sq_ctrl.adv_s3 = adv3;
    assign mg_ctrl.adv_s4 = adv4;
    assign mg_ctrl.adv_s5 = adv5;

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    assign box_lo = {s_box_min_z, s_box_min_y, s_box_min_x};
    assign box_hi = {s_box_max_z, s_box_max_y, s_box_max_x};
    assign ctr    = {s_centre_z, s_centre_y, s_centre_x};

    // One clamp lane and one squarer per axis
    for (genvar i = 0; i < NA; i++) begin : g_axis
        bso_lane #(.WIDTH(COORD_WIDTH)) u_lane (
            .aclk (aclk),
            .adv  (adv1),
            .lo   (box_lo[i]),
            .hi   (box_hi[i]),
            .c    (ctr[i]),
            .gap  (gap[i]),
            .near (near_s1[i])
        );

        bso_square #(.WIDTH(COORD_WIDTH)) u_sq (
            .aclk (aclk),
            .ctrl (sq_ctrl),
            .a    (gap[i]),
            .sq   (sq_dist[i])
        );
    end

    // Radius magnitude; the most negative value wraps to 2^(W-1) unsigned
    assign rmag_next = s_radius[COORD_WIDTH-1] ? COORD_WIDTH'(-s_radius)
                                               : COORD_WIDTH'(s_radius);

    always_ff @(posedge aclk) begin
        if (adv1) rmag_reg <= rmag_next;
    end

    bso_square #(.WIDTH(COORD_WIDTH)) u_rsq (
        .aclk (aclk),
        .ctrl (sq_ctrl),
        .a    (rmag_reg),
        .sq   (r_sq)
    );

    bso_merge #(.WIDTH(COORD_WIDTH)) u_merge (
        .aclk    (aclk),
        .ctrl    (mg_ctrl),
        .sq_dist (sq_dist),
        .r_sq    (r_sq),
        .hit     (hit)
    );

    // Nearest point rides alongside the arithmetic stages
    always_ff @(posedge aclk) begin
        if (adv2) near_s2_reg <= near_s1;
        if (adv3) near_s3_reg <= near_s2_reg;
        if (adv4) near_s4_reg <= near_s3_reg;
        if (adv5) near_s5_reg <= near_s4_reg;
    end

    assign m_valid  = v5_reg;
    assign m_hit    = hit;
    assign m_near_x = near_s5_reg[0];
    assign m_near_y = near_s5_reg[1];
    assign m_near_z = near_s5_reg[2];

endmodule

`default_nettype wire

[rtl/bso_lane.sv]
`default_nettype none

// One axis: clamp the centre to [lo, hi] and form the distance to the box.
module bso_lane #(
    parameter int WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    adv,
    input  wire logic signed [WIDTH-1:0] lo,
    input  wire logic signed [WIDTH-1:0] hi,
    input  wire logic signed [WIDTH-1:0] c,
    output logic        [WIDTH-1:0]      gap,
    output logic signed [WIDTH-1:0]      near
);

    logic        [WIDTH-1:0] dist_reg, dist_next;
    logic signed [WIDTH-1:0] near_reg, near_next;

    // Below-minimum test wins over above-maximum on an inverted box.
    // The true distance is below 2^WIDTH, so the wrapped difference is exact.
    always_comb begin
        if (c < lo) begin
            dist_next = WIDTH'(lo - c);
            near_next = lo;
        end else if (c > hi) begin
            dist_next = WIDTH'(c - hi);
            near_next = hi;
        end else begin
            dist_next = '0;
            near_next = c;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_reg <= dist_next;
            near_reg <= near_next;
        end
    end

    assign gap  = dist_reg;
    assign near = near_reg;

endmodule

`default_nettype wire

[rtl/bso_square.sv]
`default_nettype none

// Two-stage exact squarer: half-width partial products, then assembly.
module bso_square #(
    parameter int WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire bso_pkg::bso_sq_ctrl_t ctrl,
    input  wire logic [WIDTH-1:0]      a,
    output logic      [2*WIDTH-1:0]    sq
);

    localparam int LO_W = (WIDTH + 1) / 2;
    localparam int HI_W = WIDTH - LO_W;

    logic [LO_W-1:0] a0;
    logic [HI_W-1:0] a1;

    logic [2*LO_W-1:0]      p00_reg, p00_next;
    logic [LO_W+HI_W-1:0]   p01_reg, p01_next;
    logic [2*HI_W-1:0]      p11_reg, p11_next;
    logic [2*WIDTH-1:0]     sq_reg, sq_next;

    assign a0 = a[LO_W-1:0];
    assign a1 = a[WIDTH-1:LO_W];

    // Partial products
    always_comb begin
        p00_next = (2*LO_W)'(a0) * (2*LO_W)'(a0);
        p01_next = (LO_W+HI_W)'(a0) * (LO_W+HI_W)'(a1);
        p11_next = (2*HI_W)'(a1) * (2*HI_W)'(a1);
    end

    // a^2 = a1^2 * 2^(2L) + a0*a1 * 2^(L+1) + a0^2
    always_comb begin
        sq_next = ((2*WIDTH)'(p11_reg) << (2*LO_W))
                + ((2*WIDTH)'(p01_reg) << (LO_W + 1))
                + (2*WIDTH)'(p00_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv_s2) begin
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p11_reg <= p11_next;
        end
        if (ctrl.adv_s3) begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

`default_nettype wire

[rtl/bso_merge.sv]
`default_nettype none

// Merge the lanes: exact sum of axis squares, then compare with radius squared.
module bso_merge #(
    parameter int WIDTH = 32
) (
    input  wire logic                                         aclk,
    input  wire bso_pkg::bso_merge_ctrl_t                     ctrl,
    input  wire logic [bso_pkg::NUM_AXES-1:0][2*WIDTH-1:0]    sq_dist,
    input  wire logic [2*WIDTH-1:0]                           r_sq,
    output logic                                              hit
);

    localparam int SUM_W = 2*WIDTH + $clog2(bso_pkg::NUM_AXES);

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [2*WIDTH-1:0] rsq_reg;
    logic               hit_reg, hit_next;

    // Sum of squares, grown by enough bits to never overflow
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < bso_pkg::NUM_AXES; i++) begin
            sum_next = sum_next + SUM_W'(sq_dist[i]);
        end
    end

    assign hit_next = (sum_reg <= SUM_W'(rsq_reg));

    always_ff @(posedge aclk) begin
        if (ctrl.adv_s4) begin
            sum_reg <= sum_next;
            rsq_reg <= r_sq;
        end
        if (ctrl.adv_s5) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire
